/* rtl/srlt_pkg.sv */
// Shared types and constants for the symbol range lookup table.
// No dependencies; imported by every module of the block.

package srlt_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int STORED_W    = 7;
    localparam int ADDR_W      = 32;

    localparam logic [3:0] TYPE_MASK = 4'hf;
    localparam logic [3:0] FUNC_TYPE = 4'd2;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_OFFER  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    // One stored range; the end is kept instead of the length so that the
    // scan only needs two compares per entry.
    typedef struct packed {
        logic [ADDR_W-1:0] range_start;
        logic [ADDR_W-1:0] range_end;
        logic [ADDR_W-1:0] name_offset;
    } entry_t;

    typedef struct packed {
        logic accept;
        logic scan;
        logic finish_hit;
        logic finish_miss;
    } cmd_t;

    typedef struct packed {
        logic is_lookup;
        logic hit;
        logic exhausted;
    } status_t;

endpackage

/* rtl/symbol_range_lookup_table.sv */
// Top level of the symbol range lookup table.
// Depends on srlt_pkg, srlt_ctrl and srlt_dp.

// The block holds up to 64 function address ranges and answers one item at a
// time. An item is taken at a rising edge where start is high and busy is low.
// Its result appears on the result ports for exactly one cycle and is marked
// by done; the receiver cannot hold it off, so it must capture the result in
// that cycle. Only match_name_offset holds its value until the next result.
// For a clear, an offer or an unused opcode the result appears in the cycle
// after the item is taken. An offer stores the symbol only if its type nibble
// is 2 and its size is nonzero; a qualifying offer into a full table is dropped
// and reported with overflow set. A lookup walks the stored entries in the
// order they were stored, one entry per cycle through the single read port of
// the entry memory, and stops at the first range with start <= address < end,
// the end being start plus size modulo 2^32. Each entry passes the registered
// read before it is compared, and a miss is found only once the table is seen
// to be exhausted. A lookup keeps busy high until it hits or misses, and its
// result appears in the first cycle that busy is low again.
// The item after a result may be given in the cycle that done is high.
// stored_count always shows the number of entries held after the latest item.
// There is no clearing pass after reset: the table starts empty because only
// entries below the count are ever read.

module symbol_range_lookup_table
    import srlt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          opcode,
    input  logic [7:0]          sym_info,
    input  logic [ADDR_W-1:0]   sym_start,
    input  logic [ADDR_W-1:0]   sym_length,
    input  logic [ADDR_W-1:0]   sym_name_offset,
    input  logic [ADDR_W-1:0]   lookup_addr,
    output logic                done,
    output logic                found,
    output logic [ADDR_W-1:0]   match_name_offset,
    output logic                overflow,
    output logic [STORED_W-1:0] stored_count
);

    cmd_t    cmd;
    status_t status;

    // The controller sequences each item; the datapath holds all storage.
    srlt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    srlt_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .opcode            (opcode),
        .sym_info          (sym_info),
        .sym_start         (sym_start),
        .sym_length        (sym_length),
        .sym_name_offset   (sym_name_offset),
        .lookup_addr       (lookup_addr),
        .done              (done),
        .found             (found),
        .match_name_offset (match_name_offset),
        .overflow          (overflow),
        .stored_count      (stored_count)
    );

endmodule

/* rtl/srlt_ctrl.sv */
// Controller state machine for the symbol range lookup table.
// Depends on srlt_pkg; drives the datapath through cmd_t and reads status_t.

module srlt_ctrl
    import srlt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (status.is_lookup)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                busy     = 1'b1;
                cmd.scan = 1'b1;
                // A hit on the entry in the compare stage wins over the end of the table.
                if (status.hit)
                begin
                    cmd.finish_hit = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (status.exhausted)
                begin
                    cmd.finish_miss = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/srlt_dp.sv */
// Datapath of the symbol range lookup table: entry memory, count, scan
// pointer, compare stage and result registers. Depends on srlt_pkg.

module srlt_dp
    import srlt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [1:0]          opcode,
    input  logic [7:0]          sym_info,
    input  logic [ADDR_W-1:0]   sym_start,
    input  logic [ADDR_W-1:0]   sym_length,
    input  logic [ADDR_W-1:0]   sym_name_offset,
    input  logic [ADDR_W-1:0]   lookup_addr,
    output logic                done,
    output logic                found,
    output logic [ADDR_W-1:0]   match_name_offset,
    output logic                overflow,
    output logic [STORED_W-1:0] stored_count
);

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] addr_reg;
    logic              done_reg, done_next;
    logic              found_reg, found_next;
    logic              ovf_reg, ovf_next;
    logic [ADDR_W-1:0] match_reg, match_next;

    opcode_t op;
    logic    qualifies;
    logic    has_room;
    logic    do_write;
    logic    issue;
    logic    entry_match;

    assign op        = opcode_t'(opcode);
    assign qualifies = ((sym_info[3:0] & TYPE_MASK) == FUNC_TYPE) && (sym_length != '0);
    assign has_room  = (count_reg < CNT_W'(MAX_ENTRIES));
    assign do_write  = cmd.accept && (op == OP_OFFER) && qualifies && has_room;
    assign issue     = cmd.scan && (ptr_reg < count_reg);

    assign entry_match = (addr_reg >= rd_data_reg.range_start)
                      && (addr_reg < rd_data_reg.range_end);

    assign status.is_lookup = (op == OP_LOOKUP);
    assign status.hit       = pend_reg && entry_match;
    assign status.exhausted = !pend_reg && !(ptr_reg < count_reg);

    // Entry memory: one write port at the fill position, one registered read port.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[count_reg[IDX_W-1:0]] <= '{range_start: sym_start,
                                           range_end:   sym_start + sym_length,
                                           name_offset: sym_name_offset};
        end
        if (issue)
        begin
            rd_data_reg <= mem[ptr_reg[IDX_W-1:0]];
        end
        if (cmd.accept)
        begin
            addr_reg <= lookup_addr;
        end
        match_reg <= match_next;
    end

    always_comb
    begin
        count_next = count_reg;
        ptr_next   = ptr_reg;
        pend_next  = 1'b0;
        done_next  = 1'b0;
        found_next = 1'b0;
        ovf_next   = 1'b0;
        match_next = match_reg;

        if (cmd.accept)
        begin
            unique case (op)
                OP_CLEAR:
                begin
                    count_next = '0;
                    done_next  = 1'b1;
                    match_next = '0;
                end
                OP_OFFER:
                begin
                    if (qualifies)
                    begin
                        if (has_room)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    done_next  = 1'b1;
                    match_next = '0;
                end
                OP_LOOKUP:
                begin
                    ptr_next = '0;
                end
                OP_NOP:
                begin
                    done_next  = 1'b1;
                    match_next = '0;
                end
                default:
                begin
                    done_next = 1'b1;
                end
            endcase
        end
        else if (cmd.finish_hit)
        begin
            done_next  = 1'b1;
            found_next = 1'b1;
            match_next = rd_data_reg.name_offset;
        end
        else if (cmd.finish_miss)
        begin
            done_next  = 1'b1;
            match_next = '0;
        end
        else if (issue)
        begin
            ptr_next  = ptr_reg + CNT_W'(1);
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign done              = done_reg;
    assign found             = found_reg;
    assign overflow          = ovf_reg;
    assign match_name_offset = match_reg;
    assign stored_count      = STORED_W'(count_reg);

endmodule
